// ===== rtl/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared types, codes and constants for the byte-level I2C transaction
// sequencer and its result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cram_pkg;

  // Most results that one input item can cause.
  localparam int unsigned RES_MAX    = 3;
  // Depth of the result queue; must hold one item's results plus one waiting.
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [6:0]  ADDR_LOW      = 7'h08;
  localparam logic [6:0]  ADDR_HIGH     = 7'h77;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  // Input item kinds.
  localparam logic [2:0] REQ_CMD   = 3'd0;
  localparam logic [2:0] REQ_WDATA = 3'd1;
  localparam logic [2:0] REQ_RESP  = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_FAULT = 3'd4;

  // Command kinds.
  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Fault kinds.
  localparam logic [1:0] FAULT_ARB     = 2'd0;
  localparam logic [1:0] FAULT_OVERRUN = 2'd2;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_ADDR_W     = 7'b0000010,
    PH_REG        = 7'b0000100,
    PH_WAIT_WDATA = 7'b0001000,
    PH_WDATA      = 7'b0010000,
    PH_ADDR_R     = 7'b0100000,
    PH_RDATA      = 7'b1000000
  } phase_e;

  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RX_ACK  = 3'd2,
    ACT_RX_NACK = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_DATA    = 3'd5,
    ACT_DONE    = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PARAM = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_NACK_ADDR = 3'd3,
    ST_NACK_DATA = 3'd4,
    ST_ARB_LOST  = 3'd5,
    ST_BUS_ERROR = 3'd6,
    ST_OVERRUN   = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] cmd_kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_index;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       acked;
    logic [1:0] fault_kind;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  op_kind;
    logic [6:0]  target_addr;
    logic [7:0]  target_reg;
    logic [7:0]  bytes_left;
    logic [15:0] wait_ticks;
  } seq_state_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } result_t;

  typedef result_t [RES_MAX-1:0] res_vec_t;

  function automatic result_t mk_res(action_e act, logic [7:0] byte_val, status_e st);
    result_t r;
    r.action   = act;
    r.out_byte = byte_val;
    r.status   = st;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cram_step.sv =====
// ----------------------------------------------------------------------------
// I2C register access master step logic
// Next-state and result logic for one input item of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_step #(
  parameter int unsigned MAX_LENGTH = 255
) (
  input  var i2cram_pkg::item_t      item_i,
  input  var i2cram_pkg::seq_state_t cur_i,
  input  wire logic [15:0]           timeout_i,
  output var i2cram_pkg::seq_state_t nxt_o,
  output var i2cram_pkg::res_vec_t   res_o,
  output logic [1:0]                 res_n_o
);

  logic                 bad_cmd;
  logic [7:0]           left_m1;
  logic [15:0]          tick_inc;
  i2cram_pkg::status_e  fault_st;

  assign bad_cmd = (item_i.dev_addr < i2cram_pkg::ADDR_LOW) ||
                   (item_i.dev_addr > i2cram_pkg::ADDR_HIGH) ||
                   (item_i.cmd_kind > i2cram_pkg::CMD_WRITE) ||
                   ((item_i.cmd_kind == i2cram_pkg::CMD_READ) &&
                    (item_i.byte_count == 8'd0)) ||
                   (17'(item_i.byte_count) > 17'(MAX_LENGTH));

  assign left_m1  = cur_i.bytes_left - 8'd1;
  assign tick_inc = (cur_i.wait_ticks == 16'hFFFF) ? cur_i.wait_ticks
                                                   : cur_i.wait_ticks + 16'd1;

  always_comb begin
    case (item_i.fault_kind)
      i2cram_pkg::FAULT_ARB:     fault_st = i2cram_pkg::ST_ARB_LOST;
      i2cram_pkg::FAULT_OVERRUN: fault_st = i2cram_pkg::ST_OVERRUN;
      default:                   fault_st = i2cram_pkg::ST_BUS_ERROR;
    endcase
  end

  always_comb begin
    nxt_o   = cur_i;
    res_o   = '0;
    res_n_o = 2'd0;
    unique case (item_i.req_type)
      i2cram_pkg::REQ_CMD: begin
        if (cur_i.phase == i2cram_pkg::PH_IDLE) begin
          if (bad_cmd) begin
            res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_DONE, 8'd0,
                                          i2cram_pkg::ST_BAD_PARAM);
            res_n_o  = 2'd1;
          end else begin
            nxt_o.op_kind     = item_i.cmd_kind;
            nxt_o.target_addr = item_i.dev_addr;
            nxt_o.target_reg  = item_i.reg_index;
            nxt_o.bytes_left  = item_i.byte_count;
            nxt_o.wait_ticks  = 16'd0;
            nxt_o.phase       = i2cram_pkg::PH_ADDR_W;
            res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_START, 8'd0, i2cram_pkg::ST_OK);
            res_o[1] = i2cram_pkg::mk_res(i2cram_pkg::ACT_SEND, {item_i.dev_addr, 1'b0},
                                          i2cram_pkg::ST_OK);
            res_n_o  = 2'd2;
          end
        end
      end
      i2cram_pkg::REQ_WDATA: begin
        if (cur_i.phase == i2cram_pkg::PH_WAIT_WDATA) begin
          nxt_o.phase      = i2cram_pkg::PH_WDATA;
          nxt_o.wait_ticks = 16'd0;
          res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_SEND, item_i.data_byte,
                                        i2cram_pkg::ST_OK);
          res_n_o  = 2'd1;
        end
      end
      i2cram_pkg::REQ_RESP: begin
        nxt_o.wait_ticks = 16'd0;
        unique case (cur_i.phase)
          i2cram_pkg::PH_ADDR_W, i2cram_pkg::PH_REG, i2cram_pkg::PH_WDATA,
          i2cram_pkg::PH_ADDR_R: begin
            if (!item_i.acked || (cur_i.phase == i2cram_pkg::PH_ADDR_W &&
                                  cur_i.op_kind == i2cram_pkg::CMD_PROBE)) begin
              // A nack anywhere before read data, or a probe that got its ack.
              nxt_o.phase      = i2cram_pkg::PH_IDLE;
              nxt_o.bytes_left = 8'd0;
              res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_STOP, 8'd0, i2cram_pkg::ST_OK);
              res_o[1] = i2cram_pkg::mk_res(i2cram_pkg::ACT_DONE, 8'd0,
                           !item_i.acked ?
                             ((cur_i.phase == i2cram_pkg::PH_WDATA) ?
                                i2cram_pkg::ST_NACK_DATA : i2cram_pkg::ST_NACK_ADDR) :
                             i2cram_pkg::ST_OK);
              res_n_o  = 2'd2;
            end else if (cur_i.phase == i2cram_pkg::PH_ADDR_W) begin
              nxt_o.phase = i2cram_pkg::PH_REG;
              res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_SEND, cur_i.target_reg,
                                            i2cram_pkg::ST_OK);
              res_n_o  = 2'd1;
            end else if (cur_i.phase == i2cram_pkg::PH_ADDR_R) begin
              nxt_o.phase = i2cram_pkg::PH_RDATA;
              res_o[0] = i2cram_pkg::mk_res((cur_i.bytes_left == 8'd1) ?
                                              i2cram_pkg::ACT_RX_NACK :
                                              i2cram_pkg::ACT_RX_ACK,
                                            8'd0, i2cram_pkg::ST_OK);
              res_n_o  = 2'd1;
            end else if (cur_i.phase == i2cram_pkg::PH_REG &&
                         cur_i.op_kind == i2cram_pkg::CMD_READ) begin
              // Repeated start with the read address.
              nxt_o.phase = i2cram_pkg::PH_ADDR_R;
              res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_START, 8'd0, i2cram_pkg::ST_OK);
              res_o[1] = i2cram_pkg::mk_res(i2cram_pkg::ACT_SEND,
                                            {cur_i.target_addr, 1'b1}, i2cram_pkg::ST_OK);
              res_n_o  = 2'd2;
            end else begin
              // Write path: index or data byte acked.
              if (cur_i.phase == i2cram_pkg::PH_WDATA) begin
                nxt_o.bytes_left = left_m1;
              end
              if ((cur_i.phase == i2cram_pkg::PH_WDATA) ? (left_m1 == 8'd0)
                                                        : (cur_i.bytes_left == 8'd0)) begin
                nxt_o.phase      = i2cram_pkg::PH_IDLE;
                nxt_o.bytes_left = 8'd0;
                res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_STOP, 8'd0, i2cram_pkg::ST_OK);
                res_o[1] = i2cram_pkg::mk_res(i2cram_pkg::ACT_DONE, 8'd0, i2cram_pkg::ST_OK);
                res_n_o  = 2'd2;
              end else begin
                nxt_o.phase = i2cram_pkg::PH_WAIT_WDATA;
              end
            end
          end
          i2cram_pkg::PH_RDATA: begin
            res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_DATA, item_i.data_byte,
                                          i2cram_pkg::ST_OK);
            nxt_o.bytes_left = left_m1;
            if (left_m1 == 8'd0) begin
              nxt_o.phase = i2cram_pkg::PH_IDLE;
              res_o[1] = i2cram_pkg::mk_res(i2cram_pkg::ACT_STOP, 8'd0, i2cram_pkg::ST_OK);
              res_o[2] = i2cram_pkg::mk_res(i2cram_pkg::ACT_DONE, 8'd0, i2cram_pkg::ST_OK);
              res_n_o  = 2'd3;
            end else begin
              res_o[1] = i2cram_pkg::mk_res((left_m1 == 8'd1) ? i2cram_pkg::ACT_RX_NACK :
                                                                i2cram_pkg::ACT_RX_ACK,
                                            8'd0, i2cram_pkg::ST_OK);
              res_n_o  = 2'd2;
            end
          end
          default: ;
        endcase
      end
      i2cram_pkg::REQ_TICK: begin
        if (cur_i.phase != i2cram_pkg::PH_IDLE &&
            cur_i.phase != i2cram_pkg::PH_WAIT_WDATA) begin
          nxt_o.wait_ticks = tick_inc;
          if (tick_inc >= timeout_i) begin
            nxt_o.phase      = i2cram_pkg::PH_IDLE;
            nxt_o.bytes_left = 8'd0;
            nxt_o.wait_ticks = 16'd0;
            res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_STOP, 8'd0, i2cram_pkg::ST_OK);
            res_o[1] = i2cram_pkg::mk_res(i2cram_pkg::ACT_DONE, 8'd0,
                                          i2cram_pkg::ST_TIMEOUT);
            res_n_o  = 2'd2;
          end
        end
      end
      i2cram_pkg::REQ_FAULT: begin
        if (cur_i.phase != i2cram_pkg::PH_IDLE) begin
          nxt_o.phase      = i2cram_pkg::PH_IDLE;
          nxt_o.bytes_left = 8'd0;
          nxt_o.wait_ticks = 16'd0;
          res_o[0] = i2cram_pkg::mk_res(i2cram_pkg::ACT_STOP, 8'd0, i2cram_pkg::ST_OK);
          res_o[1] = i2cram_pkg::mk_res(i2cram_pkg::ACT_DONE, 8'd0, fault_st);
          res_n_o  = 2'd2;
        end
      end
      default: ;
    endcase
    // Flag the final result of this item.
    res_o[0].last = (res_n_o == 2'd1);
    res_o[1].last = (res_n_o == 2'd2);
    res_o[2].last = (res_n_o == 2'd3);
  end

endmodule

`default_nettype wire

// ===== rtl/i2cram_res_fifo.sv =====
// ----------------------------------------------------------------------------
// I2C register access master result queue
// Small register queue that takes up to three results per cycle and hands
// out one per cycle while pop_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_res_fifo (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [1:0]               push_n_i,
  input  var  i2cram_pkg::res_vec_t     push_data_i,
  input  wire logic                     pop_i,
  output var  i2cram_pkg::result_t      head_o,
  output logic [2:0]                    count_o
);

  i2cram_pkg::result_t mem_q [i2cram_pkg::FIFO_DEPTH];
  logic [1:0]          wr_ptr_q, wr_ptr_d;
  logic [1:0]          rd_ptr_q, rd_ptr_d;
  logic [2:0]          count_q, count_d;

  assign wr_ptr_d = wr_ptr_q + push_n_i;
  assign rd_ptr_d = rd_ptr_q + 2'(pop_i);
  assign count_d  = count_q + 3'(push_n_i) - 3'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < i2cram_pkg::RES_MAX; i++) begin
      if (2'(i) < push_n_i) begin
        mem_q[wr_ptr_q + 2'(i)] <= push_data_i[i];
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/i2c_register_access_master_top.sv =====
// ----------------------------------------------------------------------------
// I2C register access master, top level
// Path: an accepted input transfer waits in the input register, then the step
//   logic pushes its results into the result queue that drives the output.
// Throughput: one input transfer per cycle while each item yields at most one
//   result and the output is not stalled; several results leave one at a time.
// Reset: asynchronous, active low; idle phase, timeout register at 200.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_access_master_top #(
  parameter int unsigned MAX_LENGTH = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [1:0]  cmd_kind_i,
  input  wire logic [6:0]  dev_addr_i,
  input  wire logic [7:0]  reg_index_i,
  input  wire logic [7:0]  byte_count_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        acked_i,
  input  wire logic [1:0]  fault_kind_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       action_o,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       status_o,
  output logic             last_o,
  // Configuration channel: timeout in ticks.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  // Input register stage. The item sits here until the result queue has room
  // for everything it can produce.
  logic                   s1_valid_q;
  i2cram_pkg::item_t      s1_item_q;
  logic                   s1_go;
  logic                   in_accept;

  // Sequencer state and the timeout register.
  i2cram_pkg::seq_state_t state_q, state_d;
  logic [15:0]            timeout_q;

  // Step results on their way into the queue.
  i2cram_pkg::res_vec_t   step_res;
  logic [1:0]             step_n;
  logic [1:0]             push_n;

  // Result queue.
  i2cram_pkg::result_t    head;
  logic [2:0]             fifo_count;
  logic                   out_pop;
  logic [2:0]             fifo_after_pop;

  assign out_valid_o    = (fifo_count != 3'd0);
  assign out_pop        = out_valid_o && !out_stall_i;
  assign fifo_after_pop = fifo_count - 3'(out_pop);

  // The queue must keep room for a full burst of results from one item.
  assign s1_go      = s1_valid_q &&
                      (fifo_after_pop <= 3'(i2cram_pkg::FIFO_DEPTH - i2cram_pkg::RES_MAX));
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.req_type   <= req_type_i;
      s1_item_q.cmd_kind   <= cmd_kind_i;
      s1_item_q.dev_addr   <= dev_addr_i;
      s1_item_q.reg_index  <= reg_index_i;
      s1_item_q.byte_count <= byte_count_i;
      s1_item_q.data_byte  <= data_byte_i;
      s1_item_q.acked      <= acked_i;
      s1_item_q.fault_kind <= fault_kind_i;
    end
  end

  // Configuration writes are always taken; the user must send them only while idle, as the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= i2cram_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  i2cram_step #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_step (
    .item_i    (s1_item_q),
    .cur_i     (state_q),
    .timeout_i (timeout_q),
    .nxt_o     (state_d),
    .res_o     (step_res),
    .res_n_o   (step_n)
  );

  // State only moves when the held item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= i2cram_pkg::PH_IDLE;
      state_q.op_kind     <= '0;
      state_q.target_addr <= '0;
      state_q.target_reg  <= '0;
      state_q.bytes_left  <= '0;
      state_q.wait_ticks  <= '0;
    end else if (s1_go) begin
      state_q <= state_d;
    end
  end

  assign push_n = s1_go ? step_n : 2'd0;

  i2cram_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (step_res),
    .pop_i       (out_pop),
    .head_o      (head),
    .count_o     (fifo_count)
  );

  assign action_o   = head.action;
  assign out_byte_o = head.out_byte;
  assign status_o   = head.status;
  assign last_o     = head.last;

  // The result queue never holds more than its depth.
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= 3'(i2cram_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // An idle sequencer carries no leftover byte count or tick count.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == i2cram_pkg::PH_IDLE) |->
      (state_q.bytes_left == 8'd0 && state_q.wait_ticks == 16'd0))
    else $error("idle phase with stale counters");

  // Every item that yields results marks exactly one of them as last.
  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |-> ($countones({step_res[2].last, step_res[1].last, step_res[0].last})
               == 32'(step_n != 2'd0)))
    else $error("last flag mismatch");

endmodule

`default_nettype wire
